/* hw/rtl/sdcsr_pkg.sv */
// Shared types and constants of the strided DMA control and status registers.
// Used by sdcsr_front, sdcsr_back and the top level; depends on nothing.
package sdcsr_pkg;

    localparam int unsigned MAIN_MEM_BYTES_DEF = 8388608;
    localparam int unsigned LOCAL_BANK_BYTES   = 4096;
    localparam int unsigned LOCAL_OFS_W        = $clog2(LOCAL_BANK_BYTES);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] LEN_MASK      = 32'hFF8F_FFFF;
    localparam logic [31:0] LEN_IDLE      = 32'h0000_0FF8;
    localparam logic [31:0] LEN_SKIP_KEEP = 32'hFF80_0000;
    localparam logic [25:0] ADDR_MASK     = 26'h3FF_FFF8;
    localparam logic [11:0] PC_MASK       = 12'hFFC;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_FINISH,
        OP_NOP
    } t_op;

    typedef enum logic [3:0] {
        REG_LOCAL  = 4'd0,
        REG_MAIN   = 4'd1,
        REG_RDLEN  = 4'd2,
        REG_WRLEN  = 4'd3,
        REG_STATUS = 4'd4,
        REG_FULL   = 4'd5,
        REG_BUSY   = 4'd6,
        REG_SEMA   = 4'd7,
        REG_PC     = 4'd8
    } t_reg;

    typedef struct packed {
        t_op         op;
        t_reg        sel;
        logic [31:0] data;
    } t_entry;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_set;
        logic        irq_clear;
        logic        dma_start;
        logic        dma_to_main;
        logic [8:0]  dma_rows;
        logic [12:0] dma_row_bytes;
        logic [11:0] dma_skip;
        logic [12:0] dma_copy_bytes;
        logic [22:0] dma_finish_delay;
        logic [25:0] dma_local_addr;
        logic [25:0] dma_main_addr;
    } t_result;

endpackage

/* hw/rtl/sdcsr_front.sv */
// Front part: accepts items, classifies them into operations and queues them.
// Depends on sdcsr_pkg.
module sdcsr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic [3:0]            i_reg_index,
    input  logic [31:0]           i_write_data,
    output logic                  o_head_valid,
    output sdcsr_pkg::t_entry     o_head,
    input  logic                  i_pop
);

    sdcsr_pkg::t_entry r_mem [sdcsr_pkg::QUEUE_DEPTH];
    logic [sdcsr_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [sdcsr_pkg::QCNT_W-1:0] r_count;
    sdcsr_pkg::t_entry            entry;
    logic                         push, pop;

    // Classify: command to operation, index to register (upper indexes alias).
    always_comb begin
        case (sdcsr_pkg::t_cmd'(i_command))
            sdcsr_pkg::CMD_READ:   entry.op = sdcsr_pkg::OP_READ;
            sdcsr_pkg::CMD_WRITE:  entry.op = sdcsr_pkg::OP_WRITE;
            sdcsr_pkg::CMD_FINISH: entry.op = sdcsr_pkg::OP_FINISH;
            default:               entry.op = sdcsr_pkg::OP_NOP;
        endcase
        if (i_reg_index == sdcsr_pkg::REG_PC) begin
            entry.sel = sdcsr_pkg::REG_PC;
        end else begin
            entry.sel = sdcsr_pkg::t_reg'({1'b0, i_reg_index[2:0]});
        end
        entry.data = i_write_data;
    end

    assign o_in_ready   = (r_count != sdcsr_pkg::QCNT_W'(sdcsr_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == sdcsr_pkg::QPTR_W'(sdcsr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == sdcsr_pkg::QPTR_W'(sdcsr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/sdcsr_back.sv */
// Back part: holds the register state, executes queued operations, builds
// DMA descriptors and registers each result. Depends on sdcsr_pkg.
module sdcsr_back #(
    parameter int unsigned MAIN_MEM_BYTES = sdcsr_pkg::MAIN_MEM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  sdcsr_pkg::t_entry i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sdcsr_pkg::t_result o_res
);

    localparam logic [26:0] MAIN_END  = 27'(MAIN_MEM_BYTES);
    localparam logic [12:0] LOCAL_END = 13'(sdcsr_pkg::LOCAL_BANK_BYTES);

    logic [11:0] r_pc, n_pc;
    logic [25:0] r_local, n_local, r_main, n_main;
    logic [31:0] r_read_len, n_read_len, r_write_len, n_write_len;
    logic [31:0] r_qread_len, n_qread_len, r_qwrite_len, n_qwrite_len;
    logic        r_active, n_active, r_queued, n_queued;
    logic        r_active_to_main, n_active_to_main, r_queued_to_main, n_queued_to_main;
    logic [3:0]  r_flags, n_flags;
    logic [7:0]  r_signal, n_signal;
    logic        r_sema, n_sema;
    logic        r_out_valid;
    sdcsr_pkg::t_result r_res, res;

    logic        do_start, start_to_main, to_main;
    logic [31:0] start_len, active_len, wlen, qlen, d;
    logic [8:0]  rows;
    logic [12:0] row_bytes, local_left;
    logic [20:0] req;
    logic [26:0] main_left, copy;

    function automatic logic pair_update(input logic cur, input logic [1:0] two);
        logic v;
        v = cur;
        if (two == 2'b01) v = 1'b0;
        if (two == 2'b10) v = 1'b1;
        return v;
    endfunction

    assign o_pop       = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign d           = i_head.data;
    assign wlen        = d & sdcsr_pkg::LEN_MASK;
    assign to_main     = (i_head.sel == sdcsr_pkg::REG_WRLEN);
    assign active_len  = r_active_to_main ? r_write_len : r_read_len;
    assign qlen        = r_queued_to_main ? r_qwrite_len : r_qread_len;

    // Descriptor geometry, clamped to both memory ends.
    assign row_bytes  = {1'b0, start_len[11:3], 3'b000} + 13'd8;
    assign rows       = {1'b0, start_len[19:12]} + 9'd1;
    assign req        = 21'(rows) * 21'(row_bytes);
    assign main_left  = ({1'b0, r_main} < MAIN_END) ? (MAIN_END - {1'b0, r_main}) : '0;
    assign local_left = LOCAL_END - {1'b0, r_local[sdcsr_pkg::LOCAL_OFS_W-1:0]};

    always_comb begin
        copy = {6'b0, req};
        if (main_left < copy) copy = main_left;
        if ({14'b0, local_left} < copy) copy = {14'b0, local_left};
    end

    always_comb begin
        n_pc = r_pc; n_local = r_local; n_main = r_main;
        n_read_len = r_read_len; n_write_len = r_write_len;
        n_qread_len = r_qread_len; n_qwrite_len = r_qwrite_len;
        n_active = r_active; n_queued = r_queued;
        n_active_to_main = r_active_to_main; n_queued_to_main = r_queued_to_main;
        n_flags = r_flags; n_signal = r_signal; n_sema = r_sema;
        res = '0;
        do_start = 1'b0;
        start_len = '0;
        start_to_main = 1'b0;

        case (i_head.op)
            sdcsr_pkg::OP_READ: begin
                case (i_head.sel)
                    sdcsr_pkg::REG_PC:    res.read_data = {20'b0, r_pc};
                    sdcsr_pkg::REG_LOCAL: res.read_data = {6'b0, r_local};
                    sdcsr_pkg::REG_MAIN:  res.read_data = {6'b0, r_main};
                    sdcsr_pkg::REG_RDLEN:
                        res.read_data = (r_active ? active_len : r_read_len) & ~32'd7;
                    sdcsr_pkg::REG_WRLEN:
                        res.read_data = (r_active ? active_len : r_write_len) & ~32'd7;
                    sdcsr_pkg::REG_STATUS:
                        res.read_data = {17'b0, r_signal, r_flags[3:2], 1'b0,
                                         r_queued, r_active, r_flags[1:0]};
                    sdcsr_pkg::REG_FULL:  res.read_data = {31'b0, r_queued};
                    sdcsr_pkg::REG_BUSY:  res.read_data = {31'b0, r_active};
                    sdcsr_pkg::REG_SEMA: begin
                        res.read_data = {31'b0, r_sema};
                        n_sema = 1'b1;
                    end
                    default: res.read_data = '0;
                endcase
            end
            sdcsr_pkg::OP_WRITE: begin
                case (i_head.sel)
                    sdcsr_pkg::REG_PC:    n_pc = d[11:0] & sdcsr_pkg::PC_MASK;
                    sdcsr_pkg::REG_LOCAL: n_local = d[25:0] & sdcsr_pkg::ADDR_MASK;
                    sdcsr_pkg::REG_MAIN:  n_main = d[25:0] & sdcsr_pkg::ADDR_MASK;
                    sdcsr_pkg::REG_RDLEN, sdcsr_pkg::REG_WRLEN: begin
                        if (r_active) begin
                            // Hold the request until the running transfer ends.
                            if (to_main) n_qwrite_len = wlen;
                            else         n_qread_len = wlen;
                            n_queued = 1'b1;
                            n_queued_to_main = to_main;
                        end else begin
                            if (to_main) n_write_len = wlen;
                            else         n_read_len = wlen;
                            do_start = 1'b1;
                            start_len = wlen;
                            start_to_main = to_main;
                        end
                    end
                    sdcsr_pkg::REG_STATUS: begin
                        n_flags[0] = pair_update(r_flags[0], d[1:0]);
                        if (d[2]) n_flags[1] = 1'b0;
                        res.irq_clear = (d[4:3] == 2'b01);
                        res.irq_set   = (d[4:3] == 2'b10);
                        n_flags[2] = pair_update(r_flags[2], d[6:5]);
                        n_flags[3] = pair_update(r_flags[3], d[8:7]);
                        for (int i = 0; i < 8; i++) begin
                            n_signal[i] = pair_update(r_signal[i], d[9 + 2*i +: 2]);
                        end
                    end
                    sdcsr_pkg::REG_SEMA: n_sema = 1'b0;
                    default: ;
                endcase
            end
            sdcsr_pkg::OP_FINISH: begin
                if (r_active) begin
                    res.irq_set = 1'b1;
                    if (r_queued) begin
                        n_queued = 1'b0;
                        n_read_len = qlen;
                        n_write_len = qlen;
                        do_start = 1'b1;
                        start_len = qlen;
                        start_to_main = r_queued_to_main;
                    end else begin
                        n_active = 1'b0;
                        n_read_len = sdcsr_pkg::LEN_IDLE | (active_len & sdcsr_pkg::LEN_SKIP_KEEP);
                        n_write_len = n_read_len;
                    end
                end
            end
            default: ;
        endcase

        if (do_start) begin
            n_active = 1'b1;
            n_active_to_main = start_to_main;
            res.dma_start = 1'b1;
            res.dma_to_main = start_to_main;
            res.dma_rows = rows;
            res.dma_row_bytes = row_bytes;
            res.dma_skip = start_len[31:20];
            res.dma_copy_bytes = copy[12:0];
            res.dma_finish_delay = {req, 2'b00};
            res.dma_local_addr = r_local;
            res.dma_main_addr = r_main;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pc <= '0; r_local <= '0; r_main <= '0;
            r_read_len <= '0; r_write_len <= '0;
            r_qread_len <= '0; r_qwrite_len <= '0;
            r_active <= 1'b0; r_queued <= 1'b0;
            r_active_to_main <= 1'b0; r_queued_to_main <= 1'b0;
            r_flags <= 4'b0001;
            r_signal <= '0;
            r_sema <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_pc <= n_pc; r_local <= n_local; r_main <= n_main;
                r_read_len <= n_read_len; r_write_len <= n_write_len;
                r_qread_len <= n_qread_len; r_qwrite_len <= n_qwrite_len;
                r_active <= n_active; r_queued <= n_queued;
                r_active_to_main <= n_active_to_main;
                r_queued_to_main <= n_queued_to_main;
                r_flags <= n_flags;
                r_signal <= n_signal;
                r_sema <= n_sema;
            end
        end
    end

    a_queued_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued |-> r_active)
        else $error("transfer queued with no transfer running");

    a_start_marks_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.dma_start) |-> r_active)
        else $error("descriptor shown while no transfer is running");

    a_idle_descriptor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.dma_start) |->
            (r_res.dma_rows == '0 && r_res.dma_copy_bytes == '0))
        else $error("descriptor fields not cleared without a start");

    a_descriptor_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.dma_start) |->
            (r_res.dma_rows != '0 && r_res.dma_row_bytes[2:0] == 3'b000
             && r_res.dma_copy_bytes <= 13'd4096))
        else $error("malformed DMA descriptor");

endmodule

/* hw/rtl/strided_dma_control_and_status_registers.sv */
// Top level of the strided DMA control and status registers.
// Instantiates sdcsr_front and sdcsr_back; depends on sdcsr_pkg.
//
// Register block of a coprocessor's DMA and status interface. Each item on
// the input channel is a register read, a register write or a DMA-finished
// event, and each item gives exactly one result item. Reads return the
// register value (reading the semaphore also sets it); writing a length
// register starts a strided transfer and shows its descriptor with
// o_dma_start high, or buffers it while a transfer runs and starts it on the
// next finish event. Status writes take paired clear/set bits and raise the
// interrupt set/clear pulses. The block takes one item per cycle while the
// output side does not stall: a two-entry queue in the front decouples input
// acceptance from execution, and the back executes one queued item per cycle
// into an output register; each result passes from the queue entry to the
// output register and is held there until the output side takes it.
// The longest path is the 9 by 13 bit row-size multiply feeding
// the copy-length clamp. No bytes are moved here; the descriptor drives an
// external copy engine, which reports completion with a finish event.
module strided_dma_control_and_status_registers #(
    parameter int unsigned MAIN_MEM_BYTES = sdcsr_pkg::MAIN_MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_set,
    output logic        o_irq_clear,
    output logic        o_dma_start,
    output logic        o_dma_to_main,
    output logic [8:0]  o_dma_rows,
    output logic [12:0] o_dma_row_bytes,
    output logic [11:0] o_dma_skip,
    output logic [12:0] o_dma_copy_bytes,
    output logic [22:0] o_dma_finish_delay,
    output logic [25:0] o_dma_local_addr,
    output logic [25:0] o_dma_main_addr
);

    logic               head_valid;
    logic               pop;
    sdcsr_pkg::t_entry  head;
    sdcsr_pkg::t_result res;

    // Accept and classify items; queue them for the back.
    sdcsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Execute against the register state; hold the result until taken.
    sdcsr_back #(
        .MAIN_MEM_BYTES (MAIN_MEM_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (res)
    );

    assign o_read_data        = res.read_data;
    assign o_irq_set          = res.irq_set;
    assign o_irq_clear        = res.irq_clear;
    assign o_dma_start        = res.dma_start;
    assign o_dma_to_main      = res.dma_to_main;
    assign o_dma_rows         = res.dma_rows;
    assign o_dma_row_bytes    = res.dma_row_bytes;
    assign o_dma_skip         = res.dma_skip;
    assign o_dma_copy_bytes   = res.dma_copy_bytes;
    assign o_dma_finish_delay = res.dma_finish_delay;
    assign o_dma_local_addr   = res.dma_local_addr;
    assign o_dma_main_addr    = res.dma_main_addr;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for strided_dma_control_and_status_registers.
// Holds a cycle-free model of the register file and DMA descriptor logic and
// depends only on sdcsr_pkg and the top level of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAIN_BYTES   = sdcsr_pkg::MAIN_MEM_BYTES_DEF;
    localparam int unsigned RANDOM_ITEMS = 960;
    localparam int unsigned QUIET_LIMIT  = 400;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned RESET_CYCLES = 11;

    // Clock, reset and both channels, all known from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  in_command = sdcsr_pkg::CMD_READ;
    logic [3:0]  in_index   = sdcsr_pkg::REG_LOCAL;
    logic [31:0] in_data    = '0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    sdcsr_pkg::t_result dut_result;

    // Idle switches, flipped in stretches by the random traffic
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    // Expected results, oldest first
    sdcsr_pkg::t_result awaited_results[$];

    // Shadow copy of the block's registers
    logic [11:0] pc_q;
    logic [25:0] local_q;
    logic [25:0] main_q;
    logic [31:0] rd_len;
    logic [31:0] wr_len;
    logic [31:0] rd_len_pending;
    logic [31:0] wr_len_pending;
    logic        dma_running;
    logic        dma_pending;
    logic        running_to_main;
    logic        pending_to_main;
    logic [3:0]  status_bits;
    logic [7:0]  signal_q;
    logic        sema_taken;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    strided_dma_control_and_status_registers #(
        .MAIN_MEM_BYTES(MAIN_BYTES)
    ) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_command         (in_command),
        .i_reg_index       (in_index),
        .i_write_data      (in_data),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_read_data       (dut_result.read_data),
        .o_irq_set         (dut_result.irq_set),
        .o_irq_clear       (dut_result.irq_clear),
        .o_dma_start       (dut_result.dma_start),
        .o_dma_to_main     (dut_result.dma_to_main),
        .o_dma_rows        (dut_result.dma_rows),
        .o_dma_row_bytes   (dut_result.dma_row_bytes),
        .o_dma_skip        (dut_result.dma_skip),
        .o_dma_copy_bytes  (dut_result.dma_copy_bytes),
        .o_dma_finish_delay(dut_result.dma_finish_delay),
        .o_dma_local_addr  (dut_result.dma_local_addr),
        .o_dma_main_addr   (dut_result.dma_main_addr)
    );

    // ------------------------------------------------------------------
    // Model of the register file
    // ------------------------------------------------------------------

    // Paired control bits: 01 clears, 10 sets, anything else holds
    function automatic logic pair_bit(logic cur, logic [1:0] ctl);
        case (ctl)
            2'b01:   return 1'b0;
            2'b10:   return 1'b1;
            default: return cur;
        endcase
    endfunction

    // While a transfer runs, both length registers show the running length
    function automatic logic [31:0] length_view(logic [31:0] own);
        logic [31:0] v;
        v = dma_running ? (running_to_main ? wr_len : rd_len) : own;
        return {v[31:3], 3'b000};
    endfunction

    // Start a transfer from the current length and addresses, build its descriptor
    function automatic sdcsr_pkg::t_result describe_transfer(logic to_main);
        sdcsr_pkg::t_result d;
        logic [31:0] len;
        int unsigned rows;
        int unsigned row_bytes;
        int unsigned req;
        int unsigned main_left;
        int unsigned local_left;
        int unsigned copy;
        int unsigned delay;
        d          = '0;
        len        = to_main ? wr_len : rd_len;
        rows       = len[19:12] + 1;
        row_bytes  = {len[11:3], 3'b000} + 8;
        req        = rows * row_bytes;
        main_left  = ({6'd0, main_q} < MAIN_BYTES) ? MAIN_BYTES - main_q : 0;
        local_left = sdcsr_pkg::LOCAL_BANK_BYTES - local_q[sdcsr_pkg::LOCAL_OFS_W-1:0];
        copy       = req;
        if (main_left < copy) copy = main_left;
        if (local_left < copy) copy = local_left;
        delay      = req << 2;
        dma_running     = 1'b1;
        running_to_main = to_main;
        d.dma_start        = 1'b1;
        d.dma_to_main      = to_main;
        d.dma_rows         = rows[8:0];
        d.dma_row_bytes    = row_bytes[12:0];
        d.dma_skip         = len[31:20];
        d.dma_copy_bytes   = copy[12:0];
        d.dma_finish_delay = delay[22:0];
        d.dma_local_addr   = local_q;
        d.dma_main_addr    = main_q;
        return d;
    endfunction

    // Advance the shadow registers by one item and return its result
    function automatic sdcsr_pkg::t_result apply_register_access(sdcsr_pkg::t_cmd cmd,
                                                                 logic [3:0] idx,
                                                                 logic [31:0] data);
        sdcsr_pkg::t_result res;
        sdcsr_pkg::t_reg    sel;
        logic [31:0] len;
        logic        to_main;
        int          b;
        res = '0;
        // Indexes above the program counter fold onto the eight registers
        sel = sdcsr_pkg::t_reg'({1'b0, idx[2:0]});
        case (cmd)
            sdcsr_pkg::CMD_READ: begin
                if (idx == sdcsr_pkg::REG_PC) begin
                    res.read_data = {20'd0, pc_q};
                end else begin
                    case (sel)
                        sdcsr_pkg::REG_LOCAL: res.read_data = {6'd0, local_q};
                        sdcsr_pkg::REG_MAIN:  res.read_data = {6'd0, main_q};
                        sdcsr_pkg::REG_RDLEN: res.read_data = length_view(rd_len);
                        sdcsr_pkg::REG_WRLEN: res.read_data = length_view(wr_len);
                        sdcsr_pkg::REG_STATUS:
                            res.read_data = {17'd0, signal_q, status_bits[3:2], 1'b0,
                                             dma_pending, dma_running, status_bits[1:0]};
                        sdcsr_pkg::REG_FULL:  res.read_data = {31'd0, dma_pending};
                        sdcsr_pkg::REG_BUSY:  res.read_data = {31'd0, dma_running};
                        default: begin
                            // Reading the semaphore takes it
                            res.read_data = {31'd0, sema_taken};
                            sema_taken    = 1'b1;
                        end
                    endcase
                end
            end
            sdcsr_pkg::CMD_WRITE: begin
                if (idx == sdcsr_pkg::REG_PC) begin
                    pc_q = data[11:0] & sdcsr_pkg::PC_MASK;
                end else begin
                    case (sel)
                        sdcsr_pkg::REG_LOCAL: local_q = data[25:0] & sdcsr_pkg::ADDR_MASK;
                        sdcsr_pkg::REG_MAIN:  main_q  = data[25:0] & sdcsr_pkg::ADDR_MASK;
                        sdcsr_pkg::REG_RDLEN, sdcsr_pkg::REG_WRLEN: begin
                            to_main = (sel == sdcsr_pkg::REG_WRLEN);
                            if (dma_running) begin
                                // Buffer the request until the running one finishes
                                if (to_main) wr_len_pending = data & sdcsr_pkg::LEN_MASK;
                                else rd_len_pending = data & sdcsr_pkg::LEN_MASK;
                                dma_pending     = 1'b1;
                                pending_to_main = to_main;
                            end else begin
                                if (to_main) wr_len = data & sdcsr_pkg::LEN_MASK;
                                else rd_len = data & sdcsr_pkg::LEN_MASK;
                                res = describe_transfer(to_main);
                            end
                        end
                        sdcsr_pkg::REG_STATUS: begin
                            status_bits[0] = pair_bit(status_bits[0], data[1:0]);
                            if (data[2]) status_bits[1] = 1'b0;
                            res.irq_clear  = (data[4:3] == 2'b01);
                            res.irq_set    = (data[4:3] == 2'b10);
                            status_bits[2] = pair_bit(status_bits[2], data[6:5]);
                            status_bits[3] = pair_bit(status_bits[3], data[8:7]);
                            for (b = 0; b < 8; b++)
                                signal_q[b] = pair_bit(signal_q[b], data[9 + 2 * b +: 2]);
                        end
                        sdcsr_pkg::REG_SEMA: sema_taken = 1'b0;
                        default: ;
                    endcase
                end
            end
            sdcsr_pkg::CMD_FINISH: begin
                // A finish with nothing running changes nothing
                if (dma_running) begin
                    if (dma_pending) begin
                        len         = pending_to_main ? wr_len_pending : rd_len_pending;
                        dma_pending = 1'b0;
                        rd_len      = len;
                        wr_len      = len;
                        res         = describe_transfer(pending_to_main);
                    end else begin
                        len         = running_to_main ? wr_len : rd_len;
                        len         = sdcsr_pkg::LEN_IDLE | (len & sdcsr_pkg::LEN_SKIP_KEEP);
                        dma_running = 1'b0;
                        rd_len      = len;
                        wr_len      = len;
                    end
                    res.irq_set = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Send one item, then hold valid high so back-to-back items need no lowering
    task automatic send_item(sdcsr_pkg::t_cmd cmd, logic [3:0] idx, logic [31:0] data);
        int gap;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_index   <= idx;
        in_data    <= data;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        awaited_results.push_back(apply_register_access(cmd, idx, data));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected 0x%08h got 0x%08h",
                         results_seen, name, want, got);
        end
    endtask

    task automatic check_result();
        sdcsr_pkg::t_result want;
        results_seen++;
        if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: no result expected, got read_data 0x%08h",
                         results_seen, dut_result.read_data);
        end else begin
            want = awaited_results.pop_front();
            check_field("read_data", dut_result.read_data, want.read_data);
            check_field("irq_set", 32'(dut_result.irq_set), 32'(want.irq_set));
            check_field("irq_clear", 32'(dut_result.irq_clear), 32'(want.irq_clear));
            check_field("dma_start", 32'(dut_result.dma_start), 32'(want.dma_start));
            check_field("dma_to_main", 32'(dut_result.dma_to_main),
                        32'(want.dma_to_main));
            check_field("dma_rows", 32'(dut_result.dma_rows), 32'(want.dma_rows));
            check_field("dma_row_bytes", 32'(dut_result.dma_row_bytes),
                        32'(want.dma_row_bytes));
            check_field("dma_skip", 32'(dut_result.dma_skip), 32'(want.dma_skip));
            check_field("dma_copy_bytes", 32'(dut_result.dma_copy_bytes),
                        32'(want.dma_copy_bytes));
            check_field("dma_finish_delay", 32'(dut_result.dma_finish_delay),
                        32'(want.dma_finish_delay));
            check_field("dma_local_addr", 32'(dut_result.dma_local_addr),
                        32'(want.dma_local_addr));
            check_field("dma_main_addr", 32'(dut_result.dma_main_addr),
                        32'(want.dma_main_addr));
        end
    endtask

    // Take results, with a random stall before each one while the receiver idles
    initial begin : result_checker
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            check_result();
        end
    end

    // End the run when neither channel has moved an item for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1)
                    || (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, awaited_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, program counter, address masks, aliases and dead commands
    task automatic test_register_access();
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_STATUS, '0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_PC, 32'hFFFF_FFFF);
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_PC, '0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_LOCAL, 32'hFFFF_FFFF);
        send_item(sdcsr_pkg::CMD_READ, 4'd12, '0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_FULL, 32'hFFFF_FFFF);
        send_item(sdcsr_pkg::CMD_NONE, 4'hF, 32'hFFFF_FFFF);
    endtask

    // Transfer start, buffering, finish with and without a buffered request
    task automatic test_dma_transfers();
        // Main address past the memory end: nothing copied, largest request
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_MAIN, 32'hFFFF_FFFF);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_RDLEN, 32'hFFFF_FFFF);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_WRLEN, 32'h0000_0000);
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_BUSY, '0);
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_WRLEN, '0);
        send_item(sdcsr_pkg::CMD_FINISH, sdcsr_pkg::REG_LOCAL, '0);
        send_item(sdcsr_pkg::CMD_FINISH, sdcsr_pkg::REG_LOCAL, '0);
        send_item(sdcsr_pkg::CMD_FINISH, sdcsr_pkg::REG_LOCAL, '0);
        // Clamp by the local bank end, with the main end slightly further
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_LOCAL, 32'h0000_0FF0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_MAIN, 32'h007F_FFE8);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_WRLEN, 32'h0000_1008);
        send_item(sdcsr_pkg::CMD_FINISH, sdcsr_pkg::REG_LOCAL, '0);
        wait_for_results();
    endtask

    // Paired set and clear bits and both interrupt pulses
    task automatic test_status_bits();
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_STATUS, 32'h5555_5555);
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_STATUS, '0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_STATUS, 32'hAAAA_AAAA);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_STATUS, 32'h0000_0018);
    endtask

    task automatic test_semaphore();
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_SEMA, '0);
        send_item(sdcsr_pkg::CMD_READ, sdcsr_pkg::REG_SEMA, '0);
        send_item(sdcsr_pkg::CMD_WRITE, sdcsr_pkg::REG_SEMA, '0);
        send_item(sdcsr_pkg::CMD_READ, 4'hF, '0);
    endtask

    // Random writes, reads, finish events and noise; length writes lead the writes
    task automatic test_random_traffic();
        int unsigned counted;
        int unsigned sent;
        int          roll;
        int          finish_top;
        sdcsr_pkg::t_cmd cmd;
        logic [3:0]  idx;
        logic [31:0] data;
        sdcsr_pkg::t_reg sel;
        bit          ignored;
        counted = 0;
        sent    = 0;
        while (counted < RANDOM_ITEMS) begin
            // Change idling in stretches, including stretches with none at all
            if (sent % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin sender_idles = 1'b1; receiver_idles = 1'b1; end
                    1: begin sender_idles = 1'b0; receiver_idles = 1'b0; end
                    2: begin sender_idles = 1'b1; receiver_idles = 1'b0; end
                    default: begin sender_idles = 1'b0; receiver_idles = 1'b1; end
                endcase
            end
            if (sent % 300 == 299) wait_for_results();
            roll       = $urandom_range(0, 99);
            finish_top = dma_running ? 30 : 8;
            data       = $urandom;
            idx        = 4'($urandom_range(0, 15));
            if (roll < 3) begin
                cmd = sdcsr_pkg::CMD_NONE;
            end else if (roll < finish_top) begin
                cmd = sdcsr_pkg::CMD_FINISH;
            end else if (roll < 62) begin
                cmd = sdcsr_pkg::CMD_WRITE;
                case ($urandom_range(0, 9))
                    0: idx = sdcsr_pkg::REG_LOCAL;
                    1: begin
                        idx = sdcsr_pkg::REG_MAIN;
                        // Keep most main addresses inside memory or near its end
                        case ($urandom_range(0, 3))
                            0: ;
                            1: data = MAIN_BYTES - $urandom_range(0, 8192);
                            default: data = $urandom_range(0, MAIN_BYTES - 1);
                        endcase
                    end
                    2, 3, 4, 5: begin
                        idx = ($urandom_range(0, 1) != 0) ? sdcsr_pkg::REG_WRLEN
                                                          : sdcsr_pkg::REG_RDLEN;
                        if ($urandom_range(0, 1) != 0) data = data & 32'hFFF0_30F8;
                    end
                    6: idx = sdcsr_pkg::REG_STATUS;
                    7: idx = sdcsr_pkg::REG_SEMA;
                    8: idx = sdcsr_pkg::REG_PC;
                    default: ;
                endcase
            end else begin
                cmd = sdcsr_pkg::CMD_READ;
            end
            sel     = sdcsr_pkg::t_reg'({1'b0, idx[2:0]});
            ignored = (cmd == sdcsr_pkg::CMD_NONE)
                || (cmd == sdcsr_pkg::CMD_FINISH && !dma_running)
                || (cmd == sdcsr_pkg::CMD_WRITE && idx != sdcsr_pkg::REG_PC
                    && (sel == sdcsr_pkg::REG_FULL || sel == sdcsr_pkg::REG_BUSY));
            if (!ignored) counted++;
            sent++;
            send_item(cmd, idx, data);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : regression
        pc_q            = '0;
        local_q         = '0;
        main_q          = '0;
        rd_len          = '0;
        wr_len          = '0;
        rd_len_pending  = '0;
        wr_len_pending  = '0;
        dma_running     = 1'b0;
        dma_pending     = 1'b0;
        running_to_main = 1'b0;
        pending_to_main = 1'b0;
        status_bits     = 4'b0001;
        signal_q        = '0;
        sema_taken      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_dma_transfers();
        test_status_bits();
        test_semaphore();
        test_random_traffic();
        wait_for_results();
        // Let any stray result show up before judging
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sdcsr_pkg.sv
hw/rtl/sdcsr_front.sv
hw/rtl/sdcsr_back.sv
hw/rtl/strided_dma_control_and_status_registers.sv
tb/testbench.sv
